>>> src/terminal_escape_and_newline_mapper_assert.svh
// assertion macros shared by the mapper rtl
// no dependencies; assertions compile away under SYNTHESIS
`ifndef TERMINAL_ESCAPE_AND_NEWLINE_MAPPER_ASSERT_SVH
`define TERMINAL_ESCAPE_AND_NEWLINE_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define TENM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define TENM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define TENM_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TENM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/tenm_pkg.sv
// types, codes and the byte mapping function of the terminal mapper
// no dependencies
package tenm_pkg;

    localparam logic [7:0] CH_DEL = 8'h7f;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;

    localparam logic [1:0] DEST_PORT    = 2'd0;
    localparam logic [1:0] DEST_SCREEN  = 2'd1;
    localparam logic [1:0] DEST_COMMAND = 2'd2;

    localparam logic [2:0] REG_ESCAPE_CHAR = 3'd0;
    localparam logic [2:0] REG_OUT_MAP     = 3'd1;
    localparam logic [2:0] REG_IN_MAP      = 3'd2;
    localparam logic [2:0] REG_ECHO_MAP    = 3'd3;
    localparam logic [2:0] REG_LOCAL_ECHO  = 3'd4;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] destination;
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [4:0] escape_char;
        logic [7:0] out_map;
        logic [7:0] in_map;
        logic [7:0] echo_map;
        logic       local_echo;
    } cfg_t;

    typedef struct packed {
        logic [2:0]                   cnt;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
        logic [MAX_RESULTS-1:0][1:0]  dests;
    } rec_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } map_t;

    function automatic map_t map_byte(input logic [7:0] flags, input logic [7:0] c);
        map_t r;
        r.cnt = 2'd1;
        r.b0  = c;
        r.b1  = CH_LF;
        case (c)
            CH_DEL:
            begin
                if (flags[6]) r.b0 = CH_BS;
            end
            CH_BS:
            begin
                if (flags[7]) r.b0 = CH_DEL;
            end
            CH_CR:
            begin
                if (flags[0]) begin
                    r.b0 = CH_LF;
                end else if (flags[1]) begin
                    r.cnt = 2'd2;
                    r.b0  = CH_CR;
                end else if (flags[2]) begin
                    r.cnt = 2'd0;
                end
            end
            CH_LF:
            begin
                if (flags[3]) begin
                    r.b0 = CH_CR;
                end else if (flags[4]) begin
                    r.cnt = 2'd2;
                    r.b0  = CH_CR;
                end else if (flags[5]) begin
                    r.cnt = 2'd0;
                end
            end
            default:
            begin
                r.cnt = 2'd1;
            end
        endcase
        return r;
    endfunction

endpackage

>>> src/terminal_escape_and_newline_mapper.sv
// a byte's results are held in the queue memory and then in the output register
// throughput: one result per cycle while out_ready holds, set by the back-end drain; a byte yields 0 to 4 results
// a queue of QUEUE_DEPTH records lets the front take bytes while the back drains
// reset (async, active low) clears command mode, queue and output; registers take defaults
// depends on tenm_pkg, tenm_front, tenm_queue, tenm_back
module terminal_escape_and_newline_mapper #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tenm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tenm_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import tenm_pkg::*;

    cfg_t    cfg_reg;
    q_stat_t q_stat;
    rec_t    push_rec;
    rec_t    head;
    logic    push;
    logic    pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.escape_char <= 5'd1;
            cfg_reg.out_map     <= 8'h00;
            cfg_reg.in_map      <= 8'h00;
            cfg_reg.echo_map    <= 8'h42;
            cfg_reg.local_echo  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ESCAPE_CHAR: cfg_reg.escape_char <= cfg_data[4:0];
                REG_OUT_MAP:     cfg_reg.out_map     <= cfg_data;
                REG_IN_MAP:      cfg_reg.in_map      <= cfg_data;
                REG_ECHO_MAP:    cfg_reg.echo_map    <= cfg_data;
                REG_LOCAL_ECHO:  cfg_reg.local_echo  <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tenm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .push     (push),
        .push_rec (push_rec)
    );

    tenm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    tenm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> src/tenm_front.sv
// front end: accepts input bytes, tracks command mode, builds result records
// depends on tenm_pkg
module tenm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tenm_pkg::in_item_t in_data,
    input  tenm_pkg::cfg_t    cfg,
    input  tenm_pkg::q_stat_t q_stat,
    output logic              push,
    output tenm_pkg::rec_t    push_rec
);
    import tenm_pkg::*;

    logic       command_mode_reg;
    logic       command_mode_next;
    logic       accept;
    logic       esc_hit;
    logic       kb_path;
    map_t       pm;
    map_t       em;
    logic [1:0] np;
    logic [1:0] ne;
    logic [1:0] pdest;
    rec_t       rec;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign esc_hit  = (in_data.data_byte == {3'b000, cfg.escape_char});

    always_comb
    begin
        command_mode_next = command_mode_reg;
        kb_path           = 1'b0;
        pm                = map_byte(cfg.out_map, in_data.data_byte);
        em                = map_byte(cfg.echo_map, in_data.data_byte);
        pdest             = DEST_PORT;
        rec               = '0;
        if (in_data.cmd) begin
            pm    = map_byte(cfg.in_map, in_data.data_byte);
            pdest = DEST_SCREEN;
        end
        np = pm.cnt;
        ne = (cfg.local_echo && !in_data.cmd) ? em.cnt : 2'd0;
        if (in_data.cmd) begin
            ne = 2'd0;
            kb_path = 1'b1;
        end else if (command_mode_reg) begin
            command_mode_next = 1'b0;
            kb_path           = esc_hit;
        end else if (esc_hit) begin
            command_mode_next = 1'b1;
        end else begin
            kb_path = 1'b1;
        end

        if (!kb_path) begin
            if (command_mode_reg && !in_data.cmd) begin
                rec.cnt      = 3'd1;
                rec.bytes[0] = in_data.data_byte;
                rec.dests[0] = DEST_COMMAND;
            end
        end else begin
            rec.cnt = {1'b0, np} + {1'b0, ne};
            case (np)
                2'd0:
                begin
                    rec.bytes[0] = em.b0;
                    rec.bytes[1] = em.b1;
                    rec.dests[0] = DEST_SCREEN;
                    rec.dests[1] = DEST_SCREEN;
                end
                2'd1:
                begin
                    rec.bytes[0] = pm.b0;
                    rec.bytes[1] = em.b0;
                    rec.bytes[2] = em.b1;
                    rec.dests[0] = pdest;
                    rec.dests[1] = DEST_SCREEN;
                    rec.dests[2] = DEST_SCREEN;
                end
                default:
                begin
                    rec.bytes[0] = pm.b0;
                    rec.bytes[1] = pm.b1;
                    rec.bytes[2] = em.b0;
                    rec.bytes[3] = em.b1;
                    rec.dests[0] = pdest;
                    rec.dests[1] = pdest;
                    rec.dests[2] = DEST_SCREEN;
                    rec.dests[3] = DEST_SCREEN;
                end
            endcase
        end
    end

    assign push     = accept && (rec.cnt != 3'd0);
    assign push_rec = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            command_mode_reg <= 1'b0;
        end else if (accept) begin
            command_mode_reg <= command_mode_next;
        end
    end

endmodule

>>> src/tenm_queue.sv
// short record queue between front and back end
// depends on tenm_pkg and the assertion macro header
`include "terminal_escape_and_newline_mapper_assert.svh"
module tenm_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tenm_pkg::rec_t    push_rec,
    input  logic              pop,
    output tenm_pkg::rec_t    head,
    output tenm_pkg::q_stat_t q_stat
);
    import tenm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rec_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign head         = mem[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == FULL_CNT);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    `TENM_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, q_stat.full, !push)
    `TENM_ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, q_stat.empty, !pop)
    `TENM_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= FULL_CNT)

endmodule

>>> src/tenm_back.sv
// back end: drains queued records one result per cycle, while the output is not stalled, into the output register
// depends on tenm_pkg and the assertion macro header
`include "terminal_escape_and_newline_mapper_assert.svh"
module tenm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tenm_pkg::rec_t      head,
    input  tenm_pkg::q_stat_t   q_stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output tenm_pkg::out_item_t out_data
);
    import tenm_pkg::*;

    logic [1:0] pos_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;
    logic       step;
    logic       at_last;

    assign step      = !q_stat.empty && (!out_valid_reg || out_ready);
    assign at_last   = ({1'b0, pos_reg} == (head.cnt - 3'd1));
    assign pop       = step && at_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (step) begin
            out_data_reg.destination <= head.dests[pos_reg];
            out_data_reg.out_byte    <= head.bytes[pos_reg];
            out_data_reg.last        <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= at_last ? 2'd0 : pos_reg + 2'd1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `TENM_ASSERT_IMPLIES(a_head_nonzero, clk, rst_n, !q_stat.empty, head.cnt != 3'd0)
    `TENM_ASSERT_IMPLIES(a_pos_in_rec, clk, rst_n, !q_stat.empty, {1'b0, pos_reg} < head.cnt)
    `TENM_ASSERT_IMPLIES(a_pos_idle, clk, rst_n, q_stat.empty, pos_reg == 2'd0)

endmodule

>>> test/tb.sv
// testbench for terminal_escape_and_newline_mapper: random and directed byte traffic
// checked against a shadow routing model, with register settings changed between phases
// depends on tenm_pkg and the mapper rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tenm_pkg::*;

    localparam logic SRC_KEYBOARD = 1'b0;
    localparam logic SRC_PORT     = 1'b1;

    localparam int F_CR_LF   = 0;
    localparam int F_CR_CRLF = 1;
    localparam int F_CR_DROP = 2;
    localparam int F_LF_CR   = 3;
    localparam int F_LF_CRLF = 4;
    localparam int F_LF_DROP = 5;
    localparam int F_DEL_BS  = 6;
    localparam int F_BS_DEL  = 7;

    localparam logic [2:0] REG_FIRST_UNUSED = REG_LOCAL_ECHO + 3'd1;

    localparam cfg_t CFG_AT_RESET = '{escape_char: 5'd1, out_map: 8'h00, in_map: 8'h00,
                                      echo_map: 8'h42, local_echo: 1'b0};

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [2:0] index;
        logic [7:0] value;
    } reg_write_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    terminal_escape_and_newline_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    in_item_t   incoming_bytes[$];
    reg_write_t reg_writes[$];
    out_item_t  routed_bytes[$];
    out_item_t  step_results[$];

    cfg_t shadow = CFG_AT_RESET;
    logic in_command = 1'b0;

    logic in_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic idle_on = 1'b1;
    logic squeeze = 1'b0;
    logic squeezed = 1'b0;

    int send_gap = 0;
    int ready_gap = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int bytes_in = 0;
    int results_seen = 0;
    int command_codes = 0;
    int empty_steps = 0;
    int settings_used = 1;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        error_count++;
        if (error_count <= 50)
            $display("mismatch at cycle %0d: %s got %02h want %02h", cycle_count, what, got,
                     want);
    endtask

    function automatic void add_result(input logic [1:0] dest, input logic [7:0] b);
        step_results.push_back(out_item_t'{destination: dest, out_byte: b, last: 1'b0});
    endfunction

    function automatic void add_mapped(input logic [1:0] dest, input logic [7:0] flags,
                                       input logic [7:0] c);
        if (c == CH_DEL)
            add_result(dest, flags[F_DEL_BS] ? CH_BS : c);
        else if (c == CH_BS)
            add_result(dest, flags[F_BS_DEL] ? CH_DEL : c);
        else if (c == CH_CR)
        begin
            if (flags[F_CR_LF])
                add_result(dest, CH_LF);
            else if (flags[F_CR_CRLF])
            begin
                add_result(dest, CH_CR);
                add_result(dest, CH_LF);
            end
            else if (!flags[F_CR_DROP])
                add_result(dest, c);
        end
        else if (c == CH_LF)
        begin
            if (flags[F_LF_CR])
                add_result(dest, CH_CR);
            else if (flags[F_LF_CRLF])
            begin
                add_result(dest, CH_CR);
                add_result(dest, CH_LF);
            end
            else if (!flags[F_LF_DROP])
                add_result(dest, c);
        end
        else
            add_result(dest, c);
    endfunction

    function automatic void send_keystroke(input logic [7:0] c);
        add_mapped(DEST_PORT, shadow.out_map, c);
        if (shadow.local_echo)
            add_mapped(DEST_SCREEN, shadow.echo_map, c);
    endfunction

    function automatic void route_byte(input in_item_t item);
        logic      is_escape;
        out_item_t final_one;
        is_escape = item.data_byte == {3'b000, shadow.escape_char};
        step_results.delete();
        if (item.cmd == SRC_PORT)
            add_mapped(DEST_SCREEN, shadow.in_map, item.data_byte);
        else if (in_command)
        begin
            in_command = 1'b0;
            if (is_escape)
                send_keystroke(item.data_byte);
            else
            begin
                add_result(DEST_COMMAND, item.data_byte);
                command_codes++;
            end
        end
        else if (is_escape)
            in_command = 1'b1;
        else
            send_keystroke(item.data_byte);
        if (step_results.size() == 0)
            empty_steps++;
        else
        begin
            final_one = step_results.pop_back();
            final_one.last = 1'b1;
            step_results.push_back(final_one);
        end
        foreach (step_results[i])
            routed_bytes.push_back(step_results[i]);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (incoming_bytes.size() > 0)
            begin
                in_data  <= incoming_bytes.pop_front();
                in_valid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            cfg_valid <= 1'b0;
        else if (!cfg_valid || cfg_taken)
        begin
            if (reg_writes.size() > 0)
            begin
                {cfg_index, cfg_data} <= reg_writes.pop_front();
                cfg_valid <= 1'b1;
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    // receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (squeeze && !squeezed && in_valid)
        begin
            hold_left <= HOLD_CYCLES;
            squeezed  <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (ready_gap > 0)
        begin
            ready_gap <= ready_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            ready_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb NOT OK");
            $finish;
        end
        else if (rst_n)
        begin
            in_taken  = in_valid && in_ready;
            cfg_taken = cfg_valid && cfg_ready;
            if (cfg_taken)
            begin
                case (cfg_index)
                    REG_ESCAPE_CHAR: shadow.escape_char = cfg_data[4:0];
                    REG_OUT_MAP:     shadow.out_map = cfg_data;
                    REG_IN_MAP:      shadow.in_map = cfg_data;
                    REG_ECHO_MAP:    shadow.echo_map = cfg_data;
                    REG_LOCAL_ECHO:  shadow.local_echo = cfg_data[0];
                    default:         ;
                endcase
            end
            if (in_taken)
            begin
                bytes_in++;
                route_byte(in_data);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (routed_bytes.size() == 0)
                    flag_mismatch("result with nothing pending, byte", out_data.out_byte, '0);
                else
                begin
                    out_item_t want;
                    want = routed_bytes.pop_front();
                    if (out_data.destination !== want.destination)
                        flag_mismatch("destination", 8'(out_data.destination),
                                      8'(want.destination));
                    if (out_data.out_byte !== want.out_byte)
                        flag_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.last !== want.last)
                        flag_mismatch("last", 8'(out_data.last), 8'(want.last));
                end
            end
        end
    end

    function automatic void push_byte(input logic src, input logic [7:0] b);
        incoming_bytes.push_back(in_item_t'{cmd: src, data_byte: b});
    endfunction

    function automatic void set_registers(input logic [4:0] esc, input logic [7:0] o_map,
                                          input logic [7:0] i_map, input logic [7:0] e_map,
                                          input logic echo);
        reg_writes.push_back(reg_write_t'{index: REG_ESCAPE_CHAR, value: {3'b000, esc}});
        reg_writes.push_back(reg_write_t'{index: REG_OUT_MAP, value: o_map});
        reg_writes.push_back(reg_write_t'{index: REG_IN_MAP, value: i_map});
        reg_writes.push_back(reg_write_t'{index: REG_ECHO_MAP, value: e_map});
        reg_writes.push_back(reg_write_t'{index: REG_LOCAL_ECHO, value: {7'b0, echo}});
        settings_used++;
    endfunction

    function automatic void random_bytes(input int count);
        int       r;
        logic     src;
        logic [7:0] b;
        logic [7:0] esc;
        esc = {3'b000, shadow.escape_char};
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            src = ($urandom_range(0, 99) < 30) ? SRC_PORT : SRC_KEYBOARD;
            if (r < 15)
            begin
                push_byte(SRC_KEYBOARD, esc);
                b = ($urandom_range(0, 3) == 0) ? esc : 8'($urandom_range(0, 255));
                push_byte(SRC_KEYBOARD, b);
                n++;
            end
            else
            begin
                if (r < 25)
                    b = esc;
                else if (r < 50)
                begin
                    case ($urandom_range(0, 3))
                        0: b = CH_CR;
                        1: b = CH_LF;
                        2: b = CH_DEL;
                        default: b = CH_BS;
                    endcase
                end
                else if (r < 65)
                    b = 8'($urandom_range(0, 31));
                else
                    b = 8'($urandom_range(0, 255));
                push_byte(src, b);
            end
        end
    endfunction

    task automatic wait_registers();
        while (reg_writes.size() != 0 || cfg_valid)
            @(posedge clk);
    endtask

    task automatic settle();
        while (incoming_bytes.size() != 0 || in_valid || routed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: plain bytes, escape handling, command codes
        push_byte(SRC_KEYBOARD, 8'h61);
        push_byte(SRC_KEYBOARD, 8'h00);
        push_byte(SRC_KEYBOARD, 8'hff);
        push_byte(SRC_KEYBOARD, CH_CR);
        push_byte(SRC_PORT, 8'hff);
        push_byte(SRC_PORT, 8'h01);
        push_byte(SRC_KEYBOARD, 8'h01);
        push_byte(SRC_KEYBOARD, 8'h01);
        push_byte(SRC_KEYBOARD, 8'h01);
        push_byte(SRC_KEYBOARD, 8'h71);
        push_byte(SRC_KEYBOARD, 8'h21);
        settle();

        // ignored indexes, then cr/lf expansion on the keyboard and echo paths, cr/lf swap on the port path
        for (int k = 0; k < 3; k++)
            reg_writes.push_back(reg_write_t'{index: 3'(REG_FIRST_UNUSED + k), value: 8'hff});
        set_registers(5'd0, 8'hd2, 8'h09, 8'h12, 1'b1);
        wait_registers();
        push_byte(SRC_KEYBOARD, CH_CR);
        push_byte(SRC_KEYBOARD, CH_LF);
        push_byte(SRC_KEYBOARD, CH_DEL);
        push_byte(SRC_KEYBOARD, CH_BS);
        push_byte(SRC_PORT, CH_CR);
        push_byte(SRC_PORT, CH_LF);
        push_byte(SRC_KEYBOARD, 8'h00);
        push_byte(SRC_KEYBOARD, 8'hff);
        settle();

        // dropped cr/lf with nothing left, all flags set on the port path
        set_registers(5'd31, 8'h24, 8'hff, 8'h24, 1'b1);
        wait_registers();
        push_byte(SRC_KEYBOARD, CH_CR);
        push_byte(SRC_KEYBOARD, CH_LF);
        push_byte(SRC_PORT, CH_CR);
        push_byte(SRC_PORT, CH_LF);
        push_byte(SRC_PORT, CH_DEL);
        push_byte(SRC_PORT, CH_BS);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: set_registers(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
                1: set_registers(5'(CH_CR), 8'hff, 8'hff, 8'hff, 1'b1);
                2:
                begin
                    for (int k = 0; k < 3; k++)
                        reg_writes.push_back(reg_write_t'{index: 3'(REG_FIRST_UNUSED + k),
                                                          value: 8'($urandom_range(0, 255))});
                    set_registers(5'($urandom_range(0, 31)), 8'h00, 8'h00, 8'h00, 1'b0);
                end
                default: set_registers(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1)));
            endcase
            wait_registers();
            squeeze = (p == 0);
            idle_on = (p != 1);
            random_bytes(26);
            settle();
        end

        $display("covered %0d bytes in and %0d results out, %0d command codes, %0d silent steps",
                 bytes_in, results_seen, command_codes, empty_steps);
        $display("across %0d register settings, with random stalls and one long output hold",
                 settings_used);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/tenm_pkg.sv
src/tenm_front.sv
src/tenm_queue.sv
src/tenm_back.sv
src/terminal_escape_and_newline_mapper.sv
test/tb.sv
